// ===== src/itae_pkg.sv =====
// Shared types and constants of the indexed array table engine.
`default_nettype none

package itae_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_DROP   = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_SORT   = 3'd4,
        CMD_SEARCH = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_WR,
        S_INS_FIN,
        S_REM_RD,
        S_REM_WR,
        S_REM_FIN,
        S_SRT_LOAD,
        S_SRT_CAR,
        S_SRT_RD,
        S_SRT_WR,
        S_SRT_END,
        S_BS_RD,
        S_BS_CMP,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_IDX_DN,
        RD_IDX_UP,
        RD_ZERO,
        RD_MID
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_APPEND,
        WR_SHIFT,
        WR_INSERT,
        WR_MIN,
        WR_CARRY
    } wr_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_USED,
        IDX_POS,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef struct packed {
        logic    load_item;
        logic    set_status;
        status_t status_code;
        logic    set_found;
        logic    used_inc;
        logic    used_dec;
        idx_op_t idx_op;
        logic    lim_load;
        logic    lim_dec;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    carry_load;
        logic    carry_max;
        logic    bs_init;
        logic    bs_mid;
        logic    bs_step;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic empty;
        logic pos_gt_used;
        logic pos_ge_used;
        logic idx_gt_pos;
        logic idx_up_lt_used;
        logic idx_up_lt_lim;
        logic lim_gt_one;
        logic bs_eq;
        logic bs_gt;
        logic mid_zero;
        logic bs_cont;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/itae_ram.sv =====
// Generic single write port RAM with one registered read port.
`default_nettype none

module itae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/itae_ctrl.sv =====
// Controller state machine that sequences every table command.
`default_nettype none

module itae_ctrl
    import itae_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       dp_cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.cmd)
                    CMD_APPEND, CMD_DROP:
                    begin
                        state_next = S_DONE;
                    end
                    CMD_INSERT:
                    begin
                        if (stat.full || stat.pos_gt_used)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_INS_RD;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (stat.empty || stat.pos_ge_used)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_REM_RD;
                        end
                    end
                    CMD_SORT, CMD_SEARCH:
                    begin
                        state_next = S_SRT_LOAD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_INS_RD:
            begin
                state_next = stat.idx_gt_pos ? S_INS_WR : S_INS_FIN;
            end
            S_INS_WR:
            begin
                state_next = S_INS_RD;
            end
            S_INS_FIN:
            begin
                state_next = S_DONE;
            end
            S_REM_RD:
            begin
                state_next = stat.idx_up_lt_used ? S_REM_WR : S_REM_FIN;
            end
            S_REM_WR:
            begin
                state_next = S_REM_RD;
            end
            S_REM_FIN:
            begin
                state_next = S_DONE;
            end
            S_SRT_LOAD:
            begin
                priority if (stat.lim_gt_one)
                begin
                    state_next = S_SRT_CAR;
                end
                else if (stat.cmd == CMD_SEARCH && !stat.empty)
                begin
                    state_next = S_BS_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SRT_CAR:
            begin
                state_next = S_SRT_RD;
            end
            S_SRT_RD:
            begin
                state_next = stat.idx_up_lt_lim ? S_SRT_WR : S_SRT_END;
            end
            S_SRT_WR:
            begin
                state_next = S_SRT_RD;
            end
            S_SRT_END:
            begin
                state_next = S_SRT_LOAD;
            end
            S_BS_RD:
            begin
                state_next = S_BS_CMP;
            end
            S_BS_CMP:
            begin
                priority if (stat.bs_eq)
                begin
                    state_next = S_DONE;
                end
                else if (stat.bs_gt && stat.mid_zero)
                begin
                    state_next = S_DONE;
                end
                else if (stat.bs_cont)
                begin
                    state_next = S_BS_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        dp_cmd   = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall         = 1'b0;
                dp_cmd.load_item = in_valid;
            end
            S_DECODE:
            begin
                unique case (stat.cmd)
                    CMD_APPEND:
                    begin
                        if (stat.full)
                        begin
                            dp_cmd.set_status  = 1'b1;
                            dp_cmd.status_code = ST_FULL;
                        end
                        else
                        begin
                            dp_cmd.wr_en    = 1'b1;
                            dp_cmd.wr_sel   = WR_APPEND;
                            dp_cmd.used_inc = 1'b1;
                        end
                    end
                    CMD_DROP:
                    begin
                        if (stat.empty)
                        begin
                            dp_cmd.set_status  = 1'b1;
                            dp_cmd.status_code = ST_EMPTY;
                        end
                        else
                        begin
                            dp_cmd.used_dec = 1'b1;
                        end
                    end
                    CMD_INSERT:
                    begin
                        priority if (stat.full)
                        begin
                            dp_cmd.set_status  = 1'b1;
                            dp_cmd.status_code = ST_FULL;
                        end
                        else if (stat.pos_gt_used)
                        begin
                            dp_cmd.set_status  = 1'b1;
                            dp_cmd.status_code = ST_RANGE;
                        end
                        else
                        begin
                            dp_cmd.idx_op = IDX_USED;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        priority if (stat.empty)
                        begin
                            dp_cmd.set_status  = 1'b1;
                            dp_cmd.status_code = ST_EMPTY;
                        end
                        else if (stat.pos_ge_used)
                        begin
                            dp_cmd.set_status  = 1'b1;
                            dp_cmd.status_code = ST_RANGE;
                        end
                        else
                        begin
                            dp_cmd.idx_op = IDX_POS;
                        end
                    end
                    CMD_SORT, CMD_SEARCH:
                    begin
                        dp_cmd.lim_load = 1'b1;
                    end
                    default:
                    begin
                        dp_cmd.set_status = 1'b0;
                    end
                endcase
            end
            S_INS_RD:
            begin
                dp_cmd.rd_sel = RD_IDX_DN;
            end
            S_INS_WR:
            begin
                dp_cmd.wr_en  = 1'b1;
                dp_cmd.wr_sel = WR_SHIFT;
                dp_cmd.idx_op = IDX_DEC;
            end
            S_INS_FIN:
            begin
                dp_cmd.wr_en    = 1'b1;
                dp_cmd.wr_sel   = WR_INSERT;
                dp_cmd.used_inc = 1'b1;
            end
            S_REM_RD:
            begin
                dp_cmd.rd_sel = RD_IDX_UP;
            end
            S_REM_WR:
            begin
                dp_cmd.wr_en  = 1'b1;
                dp_cmd.wr_sel = WR_SHIFT;
                dp_cmd.idx_op = IDX_INC;
            end
            S_REM_FIN:
            begin
                dp_cmd.used_dec = 1'b1;
            end
            S_SRT_LOAD:
            begin
                dp_cmd.rd_sel = RD_ZERO;
                if (!stat.lim_gt_one && stat.cmd == CMD_SEARCH)
                begin
                    if (stat.empty)
                    begin
                        dp_cmd.set_status  = 1'b1;
                        dp_cmd.status_code = ST_NOTFOUND;
                    end
                    else
                    begin
                        dp_cmd.bs_init = 1'b1;
                    end
                end
            end
            S_SRT_CAR:
            begin
                dp_cmd.carry_load = 1'b1;
                dp_cmd.idx_op     = IDX_ZERO;
            end
            S_SRT_RD:
            begin
                dp_cmd.rd_sel = RD_IDX_UP;
            end
            S_SRT_WR:
            begin
                dp_cmd.wr_en     = 1'b1;
                dp_cmd.wr_sel    = WR_MIN;
                dp_cmd.carry_max = 1'b1;
                dp_cmd.idx_op    = IDX_INC;
            end
            S_SRT_END:
            begin
                dp_cmd.wr_en   = 1'b1;
                dp_cmd.wr_sel  = WR_CARRY;
                dp_cmd.lim_dec = 1'b1;
            end
            S_BS_RD:
            begin
                dp_cmd.rd_sel = RD_MID;
                dp_cmd.bs_mid = 1'b1;
            end
            S_BS_CMP:
            begin
                priority if (stat.bs_eq)
                begin
                    dp_cmd.set_found = 1'b1;
                end
                else if (stat.bs_gt && stat.mid_zero)
                begin
                    dp_cmd.set_status  = 1'b1;
                    dp_cmd.status_code = ST_NOTFOUND;
                end
                else
                begin
                    dp_cmd.bs_step = 1'b1;
                    if (!stat.bs_cont)
                    begin
                        dp_cmd.set_status  = 1'b1;
                        dp_cmd.status_code = ST_NOTFOUND;
                    end
                end
            end
            S_DONE:
            begin
                dp_cmd.out_load = stat.out_free;
            end
        endcase
    end

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_DECODE)
        else $error("accepted word not followed by decode");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !dp_cmd.wr_en)
        else $error("table written while idle");

    a_load_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |=> state_reg == S_IDLE && !in_stall)
        else $error("result loaded without return to idle");

endmodule

`default_nettype wire

// ===== src/itae_dp.sv =====
// Datapath with the table memory, index registers, compare logic and result register.
`default_nettype none

module itae_dp
    import itae_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic        [CMD_W-1:0]    cmd,
    input  wire logic        [POS_W-1:0]    position,
    input  wire logic signed [DATA_W-1:0]   value,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic             [STATUS_W-1:0] status,
    output logic             [FOUND_W-1:0]  found_at,
    output logic             [COUNT_W-1:0]  count,
    input  wire dp_cmd_t                    dp_cmd,
    output dp_stat_t                        stat
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    cmd_t                     cmd_reg;
    logic        [POS_W-1:0]  pos_reg;
    logic signed [DATA_W-1:0] value_reg;
    status_t                  status_reg;
    logic        [CNT_W-1:0]  found_reg;
    logic        [CNT_W-1:0]  used_reg;
    logic        [CNT_W-1:0]  used_next;
    logic        [CNT_W-1:0]  idx_reg;
    logic        [CNT_W-1:0]  lim_reg;
    logic        [CNT_W-1:0]  lo_reg;
    logic        [CNT_W-1:0]  hi_reg;
    logic        [CNT_W-1:0]  mid_reg;
    logic signed [DATA_W-1:0] carry_reg;
    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic        [FOUND_W-1:0] out_found_reg;
    logic        [COUNT_W-1:0] out_count_reg;

    logic        [CMP_W-1:0]  pos_ext;
    logic        [CMP_W-1:0]  used_ext;
    logic        [CNT_W-1:0]  idx_up;
    logic        [CNT_W-1:0]  idx_dn;
    logic        [CNT_W:0]    mid_sum;
    logic        [CNT_W-1:0]  mid_calc;
    logic        [CNT_W-1:0]  lo_new;
    logic        [CNT_W-1:0]  hi_new;
    logic                     carry_gt;
    logic                     bs_gt;

    logic        [IDX_W-1:0]  raddr;
    logic        [IDX_W-1:0]  waddr;
    logic        [DATA_W-1:0] wdata;
    logic        [DATA_W-1:0] rdata_raw;
    logic signed [DATA_W-1:0] rdata;

    itae_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (dp_cmd.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rdata    = $signed(rdata_raw);
    assign pos_ext  = CMP_W'(pos_reg);
    assign used_ext = CMP_W'(used_reg);
    assign idx_up   = idx_reg + CNT_W'(1);
    assign idx_dn   = idx_reg - CNT_W'(1);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[CNT_W:1];
    assign carry_gt = carry_reg > rdata;
    assign bs_gt    = rdata > value_reg;

    always_comb
    begin
        if (bs_gt)
        begin
            lo_new = lo_reg;
            hi_new = mid_reg - CNT_W'(1);
        end
        else
        begin
            lo_new = mid_reg + CNT_W'(1);
            hi_new = hi_reg;
        end
    end

    always_comb
    begin
        unique case (dp_cmd.rd_sel)
            RD_IDX_DN: raddr = idx_dn[IDX_W-1:0];
            RD_IDX_UP: raddr = idx_up[IDX_W-1:0];
            RD_ZERO:   raddr = '0;
            RD_MID:    raddr = mid_calc[IDX_W-1:0];
        endcase
    end

    always_comb
    begin
        unique case (dp_cmd.wr_sel)
            WR_APPEND:
            begin
                waddr = used_reg[IDX_W-1:0];
                wdata = value_reg;
            end
            WR_SHIFT:
            begin
                waddr = idx_reg[IDX_W-1:0];
                wdata = rdata;
            end
            WR_INSERT:
            begin
                waddr = pos_ext[IDX_W-1:0];
                wdata = value_reg;
            end
            WR_MIN:
            begin
                waddr = idx_reg[IDX_W-1:0];
                wdata = carry_gt ? rdata : carry_reg;
            end
            default:
            begin
                waddr = idx_reg[IDX_W-1:0];
                wdata = carry_reg;
            end
        endcase
    end

    always_comb
    begin
        used_next = used_reg;
        priority if (dp_cmd.used_inc)
        begin
            used_next = used_reg + CNT_W'(1);
        end
        else if (dp_cmd.used_dec)
        begin
            used_next = used_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            if (dp_cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_item)
        begin
            cmd_reg    <= cmd_t'(cmd);
            pos_reg    <= position;
            value_reg  <= value;
            status_reg <= ST_OK;
            found_reg  <= '0;
        end
        if (dp_cmd.set_status)
        begin
            status_reg <= dp_cmd.status_code;
        end
        if (dp_cmd.set_found)
        begin
            found_reg <= mid_reg;
        end
        unique case (dp_cmd.idx_op)
            IDX_USED: idx_reg <= used_reg;
            IDX_POS:  idx_reg <= pos_ext[CNT_W-1:0];
            IDX_ZERO: idx_reg <= '0;
            IDX_INC:  idx_reg <= idx_up;
            IDX_DEC:  idx_reg <= idx_dn;
            default:  idx_reg <= idx_reg;
        endcase
        if (dp_cmd.lim_load)
        begin
            lim_reg <= used_reg;
        end
        else if (dp_cmd.lim_dec)
        begin
            lim_reg <= lim_reg - CNT_W'(1);
        end
        if (dp_cmd.carry_load)
        begin
            carry_reg <= rdata;
        end
        else if (dp_cmd.carry_max && !carry_gt)
        begin
            carry_reg <= rdata;
        end
        if (dp_cmd.bs_init)
        begin
            lo_reg <= '0;
            hi_reg <= used_reg - CNT_W'(1);
        end
        else if (dp_cmd.bs_step)
        begin
            lo_reg <= lo_new;
            hi_reg <= hi_new;
        end
        if (dp_cmd.bs_mid)
        begin
            mid_reg <= mid_calc;
        end
        if (dp_cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_found_reg  <= FOUND_W'(found_reg);
            out_count_reg  <= COUNT_W'(used_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign found_at  = out_found_reg;
    assign count     = out_count_reg;

    assign stat.cmd            = cmd_reg;
    assign stat.full           = used_reg == CNT_W'(CAPACITY);
    assign stat.empty          = used_reg == '0;
    assign stat.pos_gt_used    = pos_ext > used_ext;
    assign stat.pos_ge_used    = pos_ext >= used_ext;
    assign stat.idx_gt_pos     = CMP_W'(idx_reg) > pos_ext;
    assign stat.idx_up_lt_used = idx_up < used_reg;
    assign stat.idx_up_lt_lim  = idx_up < lim_reg;
    assign stat.lim_gt_one     = lim_reg > CNT_W'(1);
    assign stat.bs_eq          = rdata == value_reg;
    assign stat.bs_gt          = bs_gt;
    assign stat.mid_zero       = mid_reg == '0;
    assign stat.bs_cont        = lo_new <= hi_new;
    assign stat.out_free       = !out_valid_reg || !out_stall;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != $past(used_reg) |->
            (used_reg == $past(used_reg) + CNT_W'(1)) ||
            (used_reg == $past(used_reg) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_found_reg != '0 |-> out_status_reg == ST_OK)
        else $error("position reported for an unsuccessful command");

endmodule

`default_nettype wire

// ===== src/indexed_array_table_engine.sv =====
// Indexed array table engine: a table of signed words driven by list commands.
//
// One input word carries a command (append, drop last, insert, remove, sort
// or search), a position and a value. Each command returns exactly one result
// word with a status, the found position and the entry count afterwards.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. One command is processed at a time, and in_stall is high from
// acceptance until its result is loaded into the output register.
// Append, drop and the error cases of insert and remove go from decode straight
// to the result. Insert and remove shift the entries between the position and
// the end of the table, with one table read and one write per shifted entry.
// Sort repeats a pass that carries the largest entry to the end of the unsorted
// part; search sorts the table first and then runs a binary search.
// The table memory has a single read and a single write port.
// The result waits in its register while out_stall is high; a new command may
// be accepted meanwhile, and its result is held back until the slot frees.
// Reset empties the table at once; the memory contents need no clearing.
`default_nettype none

module indexed_array_table_engine
    import itae_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic        [CMD_W-1:0]    cmd,
    input  wire logic        [POS_W-1:0]    position,
    input  wire logic signed [DATA_W-1:0]   value,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic             [STATUS_W-1:0] status,
    output logic             [FOUND_W-1:0]  found_at,
    output logic             [COUNT_W-1:0]  count
);

    dp_cmd_t  dp_cmd;
    dp_stat_t stat;

    itae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .dp_cmd   (dp_cmd)
    );

    itae_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .position  (position),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .found_at  (found_at),
        .count     (count),
        .dp_cmd    (dp_cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
